// ===== design/tqs_pkg.sv =====
// Package for the timer queue scheduler: request codes, field widths and the
// command bundle broadcast from the controller to every slot cell.
// No dependencies.
`timescale 1ns / 1ps

package tqs_pkg;

    localparam int CNT_W = 16;
    localparam int ID_W  = 4;
    localparam int REQ_W = 2;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

    typedef struct packed {
        logic             tick;
        logic             start;
        logic             stop;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] period;
        logic             periodic;
        logic [CNT_W-1:0] count;
        logic             wrap;
    } cell_cmd_t;

endpackage

// ===== design/tqs_cell.sv =====
// One timer slot of the scheduler chain: schedule state, expiry check and one
// stage of the hit shift line that carries expiries toward the controller.
// Depends on tqs_pkg.
`timescale 1ns / 1ps

module tqs_cell
    import tqs_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  logic      shift_en,
    input  logic      hit_in,
    output logic      hit_out
);

    logic             active_reg, active_next;
    logic             repeat_reg, repeat_next;
    logic             next_lap_reg, next_lap_next;
    logic             hit_reg, hit_next;
    logic [CNT_W-1:0] interval_reg, interval_next;
    logic [CNT_W-1:0] due_reg, due_next;

    logic             sel;
    logic             fire;
    logic [CNT_W-1:0] arm_ticks;
    logic [CNT_W-1:0] arm_due;
    logic             arm_late;

    always_comb begin
        sel       = (32'(cmd.id) == CELL_IDX);
        fire      = cmd.tick && active_reg && (!next_lap_reg || cmd.wrap)
                    && (due_reg == cmd.count);
        arm_ticks = cmd.start ? cmd.period : interval_reg;
        arm_due   = cmd.count + arm_ticks;
        arm_late  = (arm_due <= cmd.count);

        active_next   = active_reg;
        repeat_next   = repeat_reg;
        next_lap_next = next_lap_reg;
        interval_next = interval_reg;
        due_next      = due_reg;
        hit_next      = hit_reg;

        if (cmd.start && sel) begin
            repeat_next   = cmd.periodic;
            interval_next = cmd.period;
            due_next      = arm_due;
            next_lap_next = arm_late;
            active_next   = 1'b1;
        end else if (cmd.stop && sel) begin
            active_next   = 1'b0;
            next_lap_next = 1'b0;
        end else if (cmd.tick) begin
            if (cmd.wrap) begin
                next_lap_next = 1'b0;
            end
            if (fire) begin
                if (repeat_reg) begin
                    due_next      = arm_due;
                    next_lap_next = arm_late;
                end else begin
                    active_next = 1'b0;
                end
            end
        end

        if (cmd.tick) begin
            hit_next = fire;
        end else if (shift_en) begin
            hit_next = hit_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            repeat_reg   <= 1'b0;
            next_lap_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            active_reg   <= active_next;
            repeat_reg   <= repeat_next;
            next_lap_reg <= next_lap_next;
            hit_reg      <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        interval_reg <= interval_next;
        due_reg      <= due_next;
    end

    assign hit_out = hit_reg;

endmodule

// ===== design/timer_queue_scheduler.sv =====
// Timer queue scheduler top level: tick counter, scan controller and the
// chain of slot cells. Depends on tqs_pkg and tqs_cell.
//
// The input channel (s_valid/s_ready) takes one request per beat: a tick, a
// start of a slot or a stop of a slot. After a start or a stop the block is
// ready again in the next cycle. A tick advances the 16-bit counter and every
// slot checks for expiry in parallel at the accepting edge; the expiries then
// shift out of the cell chain one cell per cycle while the receiver keeps up,
// and s_ready stays low until the scan of the whole chain is done; the final
// beat of the tick is presented at the end of that scan. Expired slots leave
// on the result channel (m_valid/m_ready) in ascending slot order, one beat
// each, with m_last on the final beat of the tick; a tick with no expiry
// produces no beat. One expiry is held back until the next one is found so
// that m_last is known. When the receiver stalls, the chain stops shifting
// and waits. The output register lets the block take the next request while
// the final beat of a tick still waits. Synchronous reset clears the counter
// and idles all slots.
`timescale 1ns / 1ps

module timer_queue_scheduler
    import tqs_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [REQ_W-1:0] s_req_type,
    input  logic [ID_W-1:0]  s_timer_id,
    input  logic [CNT_W-1:0] s_period,
    input  logic             s_periodic,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ID_W-1:0]  m_fired_id,
    output logic             m_last
);

    localparam int IDX_W = $clog2(NUM_SLOTS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]  pend_id_reg, pend_id_next;
    logic             m_valid_reg, m_valid_next;
    logic [ID_W-1:0]  m_id_reg, m_id_next;
    logic             m_last_reg, m_last_next;

    logic             accept;
    logic             out_free;
    logic             shift_en;
    logic             head;
    cell_cmd_t        cmd;
    logic [NUM_SLOTS:0] hit_chain;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign head     = hit_chain[0];

    always_comb begin
        cmd.tick     = accept && (s_req_type == REQ_TICK);
        cmd.start    = accept && (s_req_type == REQ_START);
        cmd.stop     = accept && (s_req_type == REQ_STOP);
        cmd.id       = s_timer_id;
        cmd.period   = s_period;
        cmd.periodic = s_periodic;
        cmd.wrap     = (count_reg == {CNT_W{1'b1}});
        cmd.count    = (s_req_type == REQ_TICK) ? count_reg + 1'b1 : count_reg;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_id_next       = m_id_reg;
        m_last_next     = m_last_reg;
        shift_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.tick) begin
                    count_next = cmd.count;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg != IDX_W'(NUM_SLOTS)) begin
                    if (head && pend_valid_reg) begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_id_next    = pend_id_reg;
                            m_last_next  = 1'b0;
                            pend_id_next = ID_W'(idx_reg);
                            shift_en     = 1'b1;
                            idx_next     = idx_reg + 1'b1;
                        end
                    end else begin
                        if (head) begin
                            pend_valid_next = 1'b1;
                            pend_id_next    = ID_W'(idx_reg);
                        end
                        shift_en = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end else if (pend_valid_reg) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_id_next       = pend_id_reg;
                        m_last_next     = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_id_reg <= pend_id_next;
        m_id_reg    <= m_id_next;
        m_last_reg  <= m_last_next;
    end

    assign hit_chain[NUM_SLOTS] = 1'b0;

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        tqs_cell #(
            .CELL_IDX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .shift_en(shift_en),
            .hit_in  (hit_chain[i+1]),
            .hit_out (hit_chain[i])
        );
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_fired_id = m_id_reg;
    assign m_last     = m_last_reg;

endmodule

// ===== design/tqs_checker.sv =====
// Port-level checker for the timer queue scheduler and its bind statement.
// Depends on tqs_pkg and timer_queue_scheduler.
`timescale 1ns / 1ps

module tqs_checker
    import tqs_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [REQ_W-1:0] s_req_type,
    input logic [ID_W-1:0]  s_timer_id,
    input logic [CNT_W-1:0] s_period,
    input logic             s_periodic,
    input logic             m_valid,
    input logic             m_ready,
    input logic [ID_W-1:0]  m_fired_id,
    input logic             m_last
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fired_id) && $stable(m_last))
    else $error("result beat changed while stalled");

    // A request beat that waits keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_req_type) && $stable(s_timer_id)
            && $stable(s_period) && $stable(s_periodic))
    else $error("request beat changed while waiting");

    // An accepted tick starts a scan, so the input side is busy next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_TICK) |=> !s_ready)
    else $error("input ready right after a tick");

    // After start, stop and unused requests the input side is ready again in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type != REQ_TICK) |=> s_ready)
    else $error("input busy after a non-tick request");

    // New result beats only come out of a scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
    else $error("result beat without a tick scan");

endmodule

bind timer_queue_scheduler tqs_checker u_tqs_checker (.*);
